// ===== design/dqd_pkg.sv =====
// Shared types and constants for the DNS query name label decoder.
// No dependencies; every design file imports this package.
package dqd_pkg;

	localparam int MAX_NAME   = 255;
	localparam int BUFFER_LEN = 256;
	localparam int LIMIT_LEN  = (MAX_NAME < BUFFER_LEN) ? MAX_NAME : BUFFER_LEN;

	localparam logic [7:0] PTR_MASK = 8'hC0;
	localparam logic [7:0] DOT_CHAR = 8'h2E;
	localparam logic [7:0] ZERO_LEN = 8'h00;

	typedef enum logic [1:0] {
		KIND_CHAR       = 2'd0,
		KIND_END        = 2'd1,
		KIND_COMPRESSED = 2'd2,
		KIND_TOO_LONG   = 2'd3
	} kind_t;

	typedef struct packed {
		logic       start_req;
		logic [7:0] name_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] text_byte;
		kind_t      kind;
		logic [7:0] name_length;
	} result_t;

endpackage

// ===== design/dqd_in_stage.sv =====
// Input register of the decoder: captures one beat from the slave side.
// Depends on dqd_pkg.
module dqd_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dqd_pkg::in_item_t in_item,
	input  logic              advance,
	output logic              valid_s1,
	output dqd_pkg::in_item_t item_s1
);
	import dqd_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== design/dqd_core.sv =====
// Label decode state and per-byte decision logic.
// Depends on dqd_pkg.
module dqd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  dqd_pkg::in_item_t item_s1,
	output logic              res_valid,
	output dqd_pkg::result_t  res
);
	import dqd_pkg::*;

	logic       in_name_q;
	logic [7:0] label_left_q;
	logic [7:0] out_count_q;

	logic       in_name_d;
	logic [7:0] label_left_d;
	logic [7:0] out_count_d;
	logic       is_ptr;
	logic       is_zero;
	logic       at_limit;

	assign is_ptr   = (item_s1.name_byte & PTR_MASK) == PTR_MASK;
	assign is_zero  = item_s1.name_byte == ZERO_LEN;
	assign at_limit = {1'b0, out_count_q} >= 9'(LIMIT_LEN);

	always_comb begin
		in_name_d       = in_name_q;
		label_left_d    = label_left_q;
		out_count_d     = out_count_q;
		res_valid       = 1'b0;
		res.text_byte   = '0;
		res.kind        = KIND_CHAR;
		res.name_length = '0;
		priority if (item_s1.start_req) begin
			out_count_d = '0;
			if (is_ptr) begin
				in_name_d    = 1'b0;
				label_left_d = '0;
				res_valid    = 1'b1;
				res.kind     = KIND_COMPRESSED;
			end else if (is_zero) begin
				in_name_d    = 1'b0;
				label_left_d = '0;
				res_valid    = 1'b1;
				res.kind     = KIND_END;
			end else begin
				in_name_d    = 1'b1;
				label_left_d = item_s1.name_byte;
			end
		end else if (!in_name_q) begin
			// idle: drop the byte
		end else if (at_limit) begin
			in_name_d    = 1'b0;
			label_left_d = '0;
			res_valid    = 1'b1;
			res.kind     = KIND_TOO_LONG;
		end else if (label_left_q == '0) begin
			if (is_ptr) begin
				in_name_d    = 1'b0;
				label_left_d = '0;
				res_valid    = 1'b1;
				res.kind     = KIND_COMPRESSED;
			end else if (is_zero) begin
				in_name_d       = 1'b0;
				label_left_d    = '0;
				res_valid       = 1'b1;
				res.kind        = KIND_END;
				res.name_length = out_count_q;
			end else begin
				// inner length byte turns into a dot
				label_left_d  = item_s1.name_byte;
				out_count_d   = out_count_q + 8'd1;
				res_valid     = 1'b1;
				res.text_byte = DOT_CHAR;
			end
		end else begin
			label_left_d  = label_left_q - 8'd1;
			out_count_d   = out_count_q + 8'd1;
			res_valid     = 1'b1;
			res.text_byte = item_s1.name_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_name_q    <= 1'b0;
			label_left_q <= '0;
			out_count_q  <= '0;
		end else if (fire) begin
			in_name_q    <= in_name_d;
			label_left_q <= label_left_d;
			out_count_q  <= out_count_d;
		end
	end

	a_end_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_valid && res.kind != KIND_CHAR) |=> !in_name_q)
		else $error("name not closed after end or error");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, out_count_q} <= 9'(LIMIT_LEN))
		else $error("text count beyond limit");

	a_idle_no_label: assert property (@(posedge clk) disable iff (!arst_n)
		!in_name_q |-> label_left_q == '0)
		else $error("label bytes pending while idle");

	a_char_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_valid && res.kind == KIND_CHAR)
			|=> out_count_q == $past(out_count_q) + 8'd1)
		else $error("character emitted without count advance");

endmodule

// ===== design/dqd_out_stage.sv =====
// Result register of the decoder: holds one result beat for the master side.
// Depends on dqd_pkg.
module dqd_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic             res_valid,
	input  dqd_pkg::result_t res,
	input  logic             out_ready,
	output logic             out_valid,
	output dqd_pkg::result_t res_s2,
	output logic             advance
);
	import dqd_pkg::*;

	// the register may take a new value once it is empty or being drained
	assign advance = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			res_s2 <= res;
		end
	end

endmodule

// ===== design/dns_qname_label_decoder.sv =====
// DNS query name label decoder: length-prefixed labels in, dotted text out.
// An accepted input beat is held in the input register, and its result beat in the result register.
// Throughput: one input byte per cycle while the master side does not stall.
// Reset (arst_n low, asynchronous): pipeline empty, decoder idle, counts zero.
// Depends on dqd_pkg, dqd_in_stage, dqd_core and dqd_out_stage.
module dns_qname_label_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// slave side: encoded name bytes
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] name_byte
	input  logic        s_tuser,   // [0] start_req
	// master side: decoded text and status
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] text_byte, [15:8] name_length
	output logic [1:0]  m_tuser    // [1:0] kind
);
	import dqd_pkg::*;

	in_item_t in_item;
	in_item_t item_s1;
	logic     valid_s1;
	logic     advance;
	logic     fire;
	logic     res_valid;
	result_t  res;
	result_t  res_s2;

	assign in_item.start_req = s_tuser;
	assign in_item.name_byte = s_tdata;

	// Stage 1: input register. It advances whenever the result register
	// can take a new value, so a byte can enter every cycle unless m_tready stalls the result register.
	dqd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// Decode the byte held in stage 1 and update the name state.
	assign fire = valid_s1 && advance;

	dqd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Stage 2: result register; bytes that produce nothing leave it empty.
	dqd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.res_valid (res_valid),
		.res       (res),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.res_s2    (res_s2),
		.advance   (advance)
	);

	assign m_tdata = {res_s2.name_length, res_s2.text_byte};
	assign m_tuser = res_s2.kind;

endmodule
